@@ design/vaos_pkg.sv @@
// shared types, codes, constants and helpers of the voice allocator
package vaos_pkg;

  localparam int VOICES_DEF = 8;
  localparam int NOTE_MOD   = 11;

  localparam logic [14:0] GAIN_ONE = 15'd16384;

  // result action codes
  localparam logic [2:0] ACT_IGNORED = 3'd0;
  localparam logic [2:0] ACT_RETRIG  = 3'd1;
  localparam logic [2:0] ACT_FREE    = 3'd2;
  localparam logic [2:0] ACT_STEAL   = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;

  // compare flags of one voice entry from the shared unit
  typedef struct packed {
    logic hit;     // loaded with the requested note
    logic free;    // no age held
    logic oldest;  // sounding with age zero
    logic above;   // sounding with age above the gap
  } flags_t;

  // note modulo 11 by reciprocal multiply and one correction
  function automatic logic [3:0] mod11(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  q;
    logic [8:0]  r;
    p = 16'(v) * 16'd186;
    q = p[15:11];
    r = 9'(v) - 9'(q) * 9'(NOTE_MOD);
    if (r >= 9'(NOTE_MOD)) begin
      r = r - 9'(NOTE_MOD);
    end
    return r[3:0];
  endfunction

  // clamp a non-negative q2.14 amplitude to 1.0
  function automatic logic [14:0] clamp_gain(input logic signed [15:0] a);
    logic [14:0] m;
    m = a[14:0];
    if (m > GAIN_ONE) begin
      m = GAIN_ONE;
    end
    return m;
  endfunction

endpackage

@@ design/vaos_unit.sv @@
// shared compare and decrement unit applied to one voice entry per cycle
module vaos_unit #(
  parameter int AW = 3
) (
  input  logic                 busy_i,
  input  logic [AW-1:0]        age_i,
  input  logic                 loaded_i,
  input  logic [3:0]           note_i,
  input  logic [3:0]           n_i,
  input  logic [AW-1:0]        gap_age_i,
  output vaos_pkg::flags_t     flags_o,
  output logic [AW-1:0]        age_dec_o
);

  always_comb begin
    flags_o.hit    = loaded_i && (note_i == n_i);
    flags_o.free   = !busy_i;
    flags_o.oldest = busy_i && (age_i == '0);
    flags_o.above  = busy_i && (age_i > gap_age_i);
  end

  assign age_dec_o = age_i - AW'(1);

endmodule

@@ design/voice_allocator_oldest_steal_top.sv @@
// polyphonic voice allocator with oldest-voice stealing, top level
// usage: input channel (in_valid / in_stall) carries one word per event:
//   in_command 0 is a note_on with in_note and signed q2.14 in_amplitude,
//   in_command 1 is a voice_finished for voice in_voice.
//   output channel (out_valid / out_stall) returns exactly one word per
//   input word: chosen or released voice, action code, clamped gain and
//   the number of voices sounding afterwards.
// timing: a sequencer walks the voice table one entry a cycle through a
//   single compare / decrement unit, so the cost scales with VOICES:
//     note_on with negative amplitude        no table pass
//     note_on retrigger or free voice        a scan pass, then decide
//     note_on that steals the oldest voice   scan pass, decide, age pass
//     voice_finished on a sounding voice     voice check, then age pass
//     voice_finished ignored                 voice check only
//   in_stall is high while an event is being worked on.
// reset: synchronous active-low rst_n frees every voice, clears loaded
//   notes and the sounding count; no clearing pass is needed
// backpressure: the result sits in an output register; a new event is
//   taken while it waits, the next result holds until out_stall drops
module voice_allocator_oldest_steal_top #(
  parameter int VOICES = vaos_pkg::VOICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [7:0]         in_note,
  input  logic [2:0]         in_voice,
  input  logic signed [15:0] in_amplitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_voice_index,
  output logic [2:0]         out_action,
  output logic [14:0]        out_gain,
  output logic [3:0]         out_sounding_count
);

  // index / age width and sounding count width
  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW = $clog2(VOICES + 1);
  localparam logic [AW-1:0] LAST = AW'(VOICES - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;  // search for hit, free, oldest
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_FCHK   = 3'd3;  // check the finished voice
  localparam logic [2:0] ST_DEC    = 3'd4;  // close the age gap
  localparam logic [2:0] ST_FINAL  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;  // result waits for output slot

  // voice table
  logic [AW-1:0]     age_r    [VOICES];
  logic [AW-1:0]     age_nxt  [VOICES];
  logic [3:0]        note_r   [VOICES];
  logic [3:0]        note_nxt [VOICES];
  logic [VOICES-1:0] busy_r, busy_nxt;
  logic [VOICES-1:0] loaded_r, loaded_nxt;
  logic [SW-1:0]     sounding_r, sounding_nxt;

  // sequencer
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          op_fin_r, op_fin_nxt;
  logic [3:0]    n_r, n_nxt;
  logic [2:0]    vin_r, vin_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [AW-1:0] gap_age_r, gap_age_nxt;
  logic          hit_found_r, hit_found_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic          old_found_r, old_found_nxt;
  logic [AW-1:0] old_idx_r, old_idx_nxt;

  // pending result
  logic [2:0]  res_vidx_r, res_vidx_nxt;
  logic [2:0]  res_action_r, res_action_nxt;
  logic [14:0] res_gain_r, res_gain_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_vidx_r, out_vidx_nxt;
  logic [2:0]  out_action_r, out_action_nxt;
  logic [14:0] out_gain_r, out_gain_nxt;
  logic [3:0]  out_cnt_r, out_cnt_nxt;

  // single table read port
  logic [AW-1:0]    rd_idx;
  logic [AW+2:0]    vin_ext;
  logic [AW-1:0]    vin_idx;
  logic             vin_in_range;
  logic [SW+3:0]    cnt_ext;
  vaos_pkg::flags_t flags;
  logic [AW-1:0]    age_dec;

  function automatic logic [2:0] idx3(input logic [AW-1:0] x);
    logic [AW+2:0] e;
    e = (AW+3)'(x);
    return e[2:0];
  endfunction

  assign vin_ext      = (AW+3)'(vin_r);
  assign vin_idx      = vin_ext[AW-1:0];
  assign vin_in_range = (6'(vin_r) < 6'(VOICES));
  assign rd_idx       = (state_r == ST_FCHK) ? vin_idx : j_r;
  assign cnt_ext      = (SW+4)'(sounding_r);

  vaos_unit #(
    .AW (AW)
  ) u_unit (
    .busy_i    (busy_r[rd_idx]),
    .age_i     (age_r[rd_idx]),
    .loaded_i  (loaded_r[rd_idx]),
    .note_i    (note_r[rd_idx]),
    .n_i       (n_r),
    .gap_age_i (gap_age_r),
    .flags_o   (flags),
    .age_dec_o (age_dec)
  );

  always_comb begin
    age_nxt        = age_r;
    note_nxt       = note_r;
    busy_nxt       = busy_r;
    loaded_nxt     = loaded_r;
    sounding_nxt   = sounding_r;
    state_nxt      = state_r;
    j_nxt          = j_r;
    op_fin_nxt     = op_fin_r;
    n_nxt          = n_r;
    vin_nxt        = vin_r;
    tgt_nxt        = tgt_r;
    gap_age_nxt    = gap_age_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    old_found_nxt  = old_found_r;
    old_idx_nxt    = old_idx_r;
    res_vidx_nxt   = res_vidx_r;
    res_action_nxt = res_action_r;
    res_gain_nxt   = res_gain_r;
    out_valid_nxt  = out_valid_r;
    out_vidx_nxt   = out_vidx_r;
    out_action_nxt = out_action_r;
    out_gain_nxt   = out_gain_r;
    out_cnt_nxt    = out_cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command) begin
            op_fin_nxt = 1'b1;
            vin_nxt    = in_voice;
            state_nxt  = ST_FCHK;
          end else if (in_amplitude[15]) begin
            res_vidx_nxt   = 3'd0;
            res_action_nxt = vaos_pkg::ACT_IGNORED;
            res_gain_nxt   = 15'd0;
            state_nxt      = ST_DONE;
          end else begin
            op_fin_nxt     = 1'b0;
            n_nxt          = vaos_pkg::mod11(in_note);
            res_gain_nxt   = vaos_pkg::clamp_gain(in_amplitude);
            hit_found_nxt  = 1'b0;
            free_found_nxt = 1'b0;
            old_found_nxt  = 1'b0;
            j_nxt          = '0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // keep the first voice of each kind
        if (flags.hit && !hit_found_r) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = j_r;
        end
        if (flags.free && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = j_r;
        end
        if (flags.oldest && !old_found_r) begin
          old_found_nxt = 1'b1;
          old_idx_nxt   = j_r;
        end
        if (j_r == LAST) begin
          state_nxt = ST_DECIDE;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end

      ST_DECIDE: begin
        priority if (hit_found_r) begin
          // retrigger; a free voice becomes the newest
          if (!busy_r[hit_idx_r]) begin
            age_nxt[hit_idx_r]  = AW'(sounding_r);
            busy_nxt[hit_idx_r] = 1'b1;
            sounding_nxt        = sounding_r + SW'(1);
          end
          res_vidx_nxt   = idx3(hit_idx_r);
          res_action_nxt = vaos_pkg::ACT_RETRIG;
          state_nxt      = ST_DONE;
        end else if ((sounding_r < SW'(VOICES)) && free_found_r) begin
          age_nxt[free_idx_r]    = AW'(sounding_r);
          busy_nxt[free_idx_r]   = 1'b1;
          note_nxt[free_idx_r]   = n_r;
          loaded_nxt[free_idx_r] = 1'b1;
          sounding_nxt           = sounding_r + SW'(1);
          res_vidx_nxt           = idx3(free_idx_r);
          res_action_nxt         = vaos_pkg::ACT_FREE;
          state_nxt              = ST_DONE;
        end else begin
          // steal the oldest voice, then renumber the rest
          tgt_nxt        = old_found_r ? old_idx_r : '0;
          res_vidx_nxt   = idx3(old_found_r ? old_idx_r : '0);
          res_action_nxt = vaos_pkg::ACT_STEAL;
          gap_age_nxt    = '0;
          j_nxt          = '0;
          state_nxt      = ST_DEC;
        end
      end

      ST_FCHK: begin
        if (vin_in_range && !flags.free) begin
          gap_age_nxt = age_r[rd_idx];
          tgt_nxt     = vin_idx;
          j_nxt       = '0;
          state_nxt   = ST_DEC;
        end else begin
          res_vidx_nxt   = vin_r;
          res_action_nxt = vaos_pkg::ACT_IGNORED;
          res_gain_nxt   = 15'd0;
          state_nxt      = ST_DONE;
        end
      end

      ST_DEC: begin
        if (flags.above) begin
          age_nxt[j_r] = age_dec;
        end
        if (j_r == LAST) begin
          state_nxt = ST_FINAL;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end

      ST_FINAL: begin
        if (op_fin_r) begin
          busy_nxt[tgt_r] = 1'b0;
          if (sounding_r != '0) begin
            sounding_nxt = sounding_r - SW'(1);
          end
          res_vidx_nxt   = vin_r;
          res_action_nxt = vaos_pkg::ACT_RELEASE;
          res_gain_nxt   = 15'd0;
        end else begin
          age_nxt[tgt_r]    = AW'(sounding_r - SW'(1));
          busy_nxt[tgt_r]   = 1'b1;
          note_nxt[tgt_r]   = n_r;
          loaded_nxt[tgt_r] = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_vidx_nxt   = res_vidx_r;
          out_action_nxt = res_action_r;
          out_gain_nxt   = res_gain_r;
          out_cnt_nxt    = cnt_ext[3:0];
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      loaded_r    <= '0;
      sounding_r  <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        note_r[i] <= 4'd0;
      end
    end else begin
      busy_r      <= busy_nxt;
      loaded_r    <= loaded_nxt;
      sounding_r  <= sounding_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      note_r      <= note_nxt;
    end
  end

  // payload and working registers, no reset
  always_ff @(posedge clk) begin
    age_r        <= age_nxt;
    j_r          <= j_nxt;
    op_fin_r     <= op_fin_nxt;
    n_r          <= n_nxt;
    vin_r        <= vin_nxt;
    tgt_r        <= tgt_nxt;
    gap_age_r    <= gap_age_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    old_found_r  <= old_found_nxt;
    old_idx_r    <= old_idx_nxt;
    res_vidx_r   <= res_vidx_nxt;
    res_action_r <= res_action_nxt;
    res_gain_r   <= res_gain_nxt;
    out_vidx_r   <= out_vidx_nxt;
    out_action_r <= out_action_nxt;
    out_gain_r   <= out_gain_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_voice_index    = out_vidx_r;
  assign out_action         = out_action_r;
  assign out_gain           = out_gain_r;
  assign out_sounding_count = out_cnt_r;

  // sounding count never exceeds the voice count
  a_sounding_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sounding_r <= SW'(VOICES))
    else $error("sounding count above voice count");

  // between events the busy voices match the sounding count
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(busy_r) == 32'(sounding_r)))
    else $error("busy voices disagree with sounding count");

  // the gap-closing pass always starts at the first voice
  a_dec_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC && $past(state_r) != ST_DEC) |-> (j_r == '0))
    else $error("age renumbering did not start at voice zero");

  // a voice taken from the free pool leaves at least one sounding
  a_free_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == vaos_pkg::ACT_FREE) |-> (out_sounding_count != 4'd0))
    else $error("free voice taken but nothing sounding");

endmodule
